// ===== rtl/ntctf_pkg.sv =====
// Shared types, constants and the log2 helper function of the NTC temperature filter.
package ntctf_pkg;

	localparam int AdcBits = 12;
	localparam int TempW   = 14;
	localparam int CalW    = 4;
	localparam int CntW    = 6;

	localparam int ChipMv     = 3300;
	localparam int DividerOhm = 10000;
	localparam int ZeroCQ15   = 273 * 32768;
	localparam int TempMin    = -1000;
	localparam int TempMax    = 6000;
	localparam int SlopeQ32   = 749885;

	// 1/298 K in Q48, rounded
	localparam logic [63:0] InvRefQ48 = ((64'd1 << 48) + 64'd149) / 64'd298;

	// floor(x / 5) as (x * DivFiveRecip) >> DivFiveShift, exact for x < 2^18
	localparam logic [16:0] DivFiveRecip = 17'd52429;
	localparam int          DivFiveShift = 18;

	// Iteration counts, loaded as count - 1
	localparam logic [CntW-1:0] Div1Last = CntW'(24);
	localparam logic [CntW-1:0] SqLast   = CntW'(15);
	localparam logic [CntW-1:0] Div2Last = CntW'(63);

	// log2 in Q16 by repeated squaring (elaboration only)
	function automatic logic [31:0] lg_q16(input logic [31:0] x);
		logic [4:0]  e;
		logic [15:0] frac;
		logic [63:0] m;
		e    = '0;
		frac = '0;
		for (int b = 0; b < 32; b++) begin
			if (x[b]) e = 5'(b);
		end
		m = {32'd0, x} << (5'd31 - e);
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m[32]) begin
				frac[i] = 1'b1;
				m = m >> 1;
			end
		end
		return {11'd0, e, frac};
	endfunction

	localparam logic [31:0] LgRef = lg_q16(32'(DividerOhm));

	typedef enum logic [4:0] {
		S_IDLE, S_MV, S_CHK, S_DIV1, S_NORM_LD, S_NORM, S_SQ_MUL, S_SQ_ADJ,
		S_SLOPE, S_INV, S_CHK2, S_DIV2, S_BLEND, S_SCALE, S_FINAL, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_MV, OP_HOLD, OP_HOT, OP_DIV1_LD, OP_DIV_STEP,
		OP_NORM_LD, OP_NORM_STEP, OP_SQ_MUL, OP_SQ_ADJ, OP_SLOPE, OP_INV,
		OP_DIV2_LD, OP_BLEND, OP_SCALE, OP_FINAL_OP, OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [3:0] bit_idx;
	} cmd_t;

	typedef struct packed {
		logic sample_zero;
		logic mv_zero;
		logic norm_done;
		logic inv_nonpos;
	} stat_t;

endpackage

// ===== rtl/ntctf_ctrl.sv =====
// Sequencer of the NTC temperature filter: steps the datapath through one sample.
module ntctf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_free,
	input  ntctf_pkg::stat_t  stat,
	output logic              in_ready,
	output ntctf_pkg::cmd_t   cmd
);

	ntctf_pkg::state_t state_q, state_d;
	logic [ntctf_pkg::CntW-1:0] cnt_q;
	logic cnt_zero;

	assign cnt_zero = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ntctf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ntctf_pkg::S_CHK:   cnt_q <= ntctf_pkg::Div1Last;
				ntctf_pkg::S_NORM:  cnt_q <= ntctf_pkg::SqLast;
				ntctf_pkg::S_CHK2:  cnt_q <= ntctf_pkg::Div2Last;
				ntctf_pkg::S_DIV1, ntctf_pkg::S_DIV2,
				ntctf_pkg::S_SQ_ADJ: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ntctf_pkg::S_IDLE:    if (in_valid) state_d = ntctf_pkg::S_MV;
			ntctf_pkg::S_MV:      state_d = stat.sample_zero ? ntctf_pkg::S_DONE : ntctf_pkg::S_CHK;
			ntctf_pkg::S_CHK:     state_d = stat.mv_zero ? ntctf_pkg::S_DONE : ntctf_pkg::S_DIV1;
			ntctf_pkg::S_DIV1:    if (cnt_zero) state_d = ntctf_pkg::S_NORM_LD;
			ntctf_pkg::S_NORM_LD: state_d = ntctf_pkg::S_NORM;
			ntctf_pkg::S_NORM:    if (stat.norm_done) state_d = ntctf_pkg::S_SQ_MUL;
			ntctf_pkg::S_SQ_MUL:  state_d = ntctf_pkg::S_SQ_ADJ;
			ntctf_pkg::S_SQ_ADJ:  state_d = cnt_zero ? ntctf_pkg::S_SLOPE : ntctf_pkg::S_SQ_MUL;
			ntctf_pkg::S_SLOPE:   state_d = ntctf_pkg::S_INV;
			ntctf_pkg::S_INV:     state_d = ntctf_pkg::S_CHK2;
			ntctf_pkg::S_CHK2:    state_d = stat.inv_nonpos ? ntctf_pkg::S_DONE : ntctf_pkg::S_DIV2;
			ntctf_pkg::S_DIV2:    if (cnt_zero) state_d = ntctf_pkg::S_BLEND;
			ntctf_pkg::S_BLEND:   state_d = ntctf_pkg::S_SCALE;
			ntctf_pkg::S_SCALE:   state_d = ntctf_pkg::S_FINAL;
			ntctf_pkg::S_FINAL:   state_d = ntctf_pkg::S_DONE;
			ntctf_pkg::S_DONE:    if (out_free) state_d = ntctf_pkg::S_IDLE;
			default:              state_d = ntctf_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.op      = ntctf_pkg::OP_NONE;
		cmd.bit_idx = cnt_q[3:0];
		unique case (state_q)
			ntctf_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = ntctf_pkg::OP_LOAD;
			end
			ntctf_pkg::S_MV:
				cmd.op = stat.sample_zero ? ntctf_pkg::OP_HOLD : ntctf_pkg::OP_MV;
			ntctf_pkg::S_CHK:
				cmd.op = stat.mv_zero ? ntctf_pkg::OP_HOT : ntctf_pkg::OP_DIV1_LD;
			ntctf_pkg::S_DIV1, ntctf_pkg::S_DIV2:
				cmd.op = ntctf_pkg::OP_DIV_STEP;
			ntctf_pkg::S_NORM_LD: cmd.op = ntctf_pkg::OP_NORM_LD;
			ntctf_pkg::S_NORM:
				if (!stat.norm_done) cmd.op = ntctf_pkg::OP_NORM_STEP;
			ntctf_pkg::S_SQ_MUL:  cmd.op = ntctf_pkg::OP_SQ_MUL;
			ntctf_pkg::S_SQ_ADJ:  cmd.op = ntctf_pkg::OP_SQ_ADJ;
			ntctf_pkg::S_SLOPE:   cmd.op = ntctf_pkg::OP_SLOPE;
			ntctf_pkg::S_INV:     cmd.op = ntctf_pkg::OP_INV;
			ntctf_pkg::S_CHK2:
				cmd.op = stat.inv_nonpos ? ntctf_pkg::OP_HOT : ntctf_pkg::OP_DIV2_LD;
			ntctf_pkg::S_BLEND:   cmd.op = ntctf_pkg::OP_BLEND;
			ntctf_pkg::S_SCALE:   cmd.op = ntctf_pkg::OP_SCALE;
			ntctf_pkg::S_FINAL:   cmd.op = ntctf_pkg::OP_FINAL_OP;
			ntctf_pkg::S_DONE:
				if (out_free) cmd.op = ntctf_pkg::OP_PUBLISH;
			default: cmd.op = ntctf_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== rtl/ntctf_dp.sv =====
// Datapath of the NTC temperature filter: divider, log2 squarer, blend and output register.
module ntctf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ntctf_pkg::cmd_t               cmd,
	input  logic [ntctf_pkg::AdcBits-1:0] sample,
	input  logic                          cfg_we,
	input  logic [ntctf_pkg::CalW-1:0]    cfg_wdata,
	output ntctf_pkg::stat_t              stat,
	output logic [ntctf_pkg::TempW-1:0]   out_temp,
	output logic                          out_flag
);

	localparam int PW = ntctf_pkg::AdcBits + 12;
	localparam logic signed [20:0] K1 = 21'(ntctf_pkg::SlopeQ32);

	logic [ntctf_pkg::AdcBits-1:0] sample_q;
	logic [11:0]  mv_q;
	logic [63:0]  dvd_q;
	logic [47:0]  rem_q, div_q;
	logic [31:0]  quot_q, man_q;
	logic [4:0]   exp_q;
	logic [15:0]  frac_q;
	logic [63:0]  prod_q;
	logic signed [47:0] slope_q, inv_q;
	logic         neg_q;
	logic [16:0]  blend_q;
	logic signed [ntctf_pkg::TempW-1:0] res_q, out_temp_q;
	logic         res_flag_q, out_flag_q;
	logic signed [ntctf_pkg::CalW-1:0] cal_q;

	logic [PW-1:0] mv_prod;
	logic [25:0]   ohm_num;
	logic [48:0]   rem2, rem_sub;
	logic          ge;
	logic [32:0]   sq;
	logic signed [22:0] d23;
	logic signed [43:0] slope_c;
	logic signed [33:0] t_c;
	logic signed [39:0] num_c, abs_c;
	logic [33:0]   scale_c;
	logic signed [26:0] q27, cal27, sum27;
	logic signed [ntctf_pkg::TempW-1:0] clamp_c;

	assign mv_prod = PW'(sample_q) * PW'(ntctf_pkg::ChipMv);
	assign ohm_num = 26'(mv_q) * 26'(ntctf_pkg::DividerOhm);

	// restoring divide step
	assign rem2    = {rem_q, dvd_q[63]};
	assign ge      = (rem2 >= {1'b0, div_q});
	assign rem_sub = rem2 - {1'b0, div_q};

	assign sq = prod_q[63:31];

	assign d23     = $signed({2'b00, exp_q, frac_q}) - $signed(23'(ntctf_pkg::LgRef));
	assign slope_c = d23 * K1;

	assign t_c   = $signed({2'b00, quot_q}) - 34'(ntctf_pkg::ZeroCQ15);
	assign num_c = (40'(out_temp_q) <<< 17) + (40'(t_c) <<< 3) + (40'(t_c) <<< 1);
	assign abs_c = num_c[39] ? -num_c : num_c;

	// |num| stays below 2^30, so the scaled magnitude fits 17 bits; divide by 5 by reciprocal
	assign scale_c = 34'(blend_q) * 34'(ntctf_pkg::DivFiveRecip);

	always_comb begin
		q27   = $signed({1'b0, quot_q[25:0]});
		if (neg_q) q27 = -q27;
		cal27 = 27'(cal_q);
		sum27 = q27 + cal27 + (cal27 <<< 1);
		if (sum27 < 27'(ntctf_pkg::TempMin))      clamp_c = 14'(ntctf_pkg::TempMin);
		else if (sum27 > 27'(ntctf_pkg::TempMax)) clamp_c = 14'(ntctf_pkg::TempMax);
		else                                      clamp_c = 14'(sum27);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q      <= '0;
			out_temp_q <= '0;
			out_flag_q <= 1'b0;
		end else begin
			if (cfg_we) cal_q <= cfg_wdata;
			if (cmd.op == ntctf_pkg::OP_PUBLISH) begin
				out_temp_q <= res_q;
				out_flag_q <= res_flag_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ntctf_pkg::OP_LOAD: sample_q <= sample;
			ntctf_pkg::OP_MV:   mv_q <= mv_prod[PW-1:ntctf_pkg::AdcBits];
			ntctf_pkg::OP_HOLD: begin
				res_q      <= out_temp_q;
				res_flag_q <= 1'b0;
			end
			ntctf_pkg::OP_HOT: begin
				res_q      <= 14'(ntctf_pkg::TempMax);
				res_flag_q <= 1'b1;
			end
			ntctf_pkg::OP_DIV1_LD: begin
				dvd_q  <= {ohm_num[24:0], 39'd0};
				div_q  <= 48'(12'(ntctf_pkg::ChipMv) - mv_q);
				rem_q  <= '0;
				quot_q <= '0;
			end
			ntctf_pkg::OP_DIV_STEP: begin
				rem_q  <= ge ? rem_sub[47:0] : rem2[47:0];
				dvd_q  <= dvd_q << 1;
				quot_q <= {quot_q[30:0], ge};
			end
			ntctf_pkg::OP_NORM_LD: begin
				man_q  <= quot_q;
				exp_q  <= 5'd31;
				frac_q <= '0;
			end
			ntctf_pkg::OP_NORM_STEP: begin
				man_q <= man_q << 1;
				exp_q <= exp_q - 1'b1;
			end
			ntctf_pkg::OP_SQ_MUL: prod_q <= 64'(man_q) * 64'(man_q);
			ntctf_pkg::OP_SQ_ADJ: begin
				if (sq[32]) begin
					frac_q[cmd.bit_idx] <= 1'b1;
					man_q <= sq[32:1];
				end else begin
					man_q <= sq[31:0];
				end
			end
			ntctf_pkg::OP_SLOPE: slope_q <= 48'(slope_c);
			ntctf_pkg::OP_INV:   inv_q <= slope_q + $signed(ntctf_pkg::InvRefQ48[47:0]);
			ntctf_pkg::OP_DIV2_LD: begin
				dvd_q  <= 64'h8000_0000_0000_0000;
				div_q  <= inv_q;
				rem_q  <= '0;
				quot_q <= '0;
			end
			ntctf_pkg::OP_BLEND: begin
				neg_q   <= num_c[39];
				blend_q <= abs_c[31:15];
			end
			ntctf_pkg::OP_SCALE: quot_q <= 32'(scale_c[33:ntctf_pkg::DivFiveShift]);
			ntctf_pkg::OP_FINAL_OP: begin
				res_q      <= clamp_c;
				res_flag_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign stat.sample_zero = (sample_q == '0);
	assign stat.mv_zero     = (mv_q == '0);
	assign stat.norm_done   = man_q[31];
	assign stat.inv_nonpos  = inv_q[47] | (inv_q == '0);

	assign out_temp = out_temp_q;
	assign out_flag = out_flag_q;

endmodule

// ===== rtl/ntc_thermistor_temperature_filter.sv =====
// Top level of the NTC temperature filter: sequencer, datapath and output beat stage.
// Steps: a zero sample or a zero-resistance one goes straight to the result; any other
//   runs serial dividers of 25 and 64 steps, 16 square-and-test rounds of the log2 unit,
//   a normalise walk of 7 to 30 steps and a divide by 5 by reciprocal.
// Throughput: one sample at a time; the next beat is taken once the result is parked.
// Reset: arst_n clears the sequencer, the calibration register and the last output to 0.
module ntc_thermistor_temperature_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] adc_sample, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [13:0] temp_tenths, rest zero
	output logic        m_tuser,   // [0] sample_valid
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata  // cal_offset
);

	ntctf_pkg::cmd_t  cmd;
	ntctf_pkg::stat_t stat;
	logic                          m_tvalid_q;
	logic                          out_free;
	logic                          publish;
	logic [ntctf_pkg::TempW-1:0]   out_temp;
	logic                          out_flag;

	// output slot is free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;
	assign publish  = (cmd.op == ntctf_pkg::OP_PUBLISH);

	ntctf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	ntctf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample    (s_tdata[ntctf_pkg::AdcBits-1:0]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.out_temp  (out_temp),
		.out_flag  (out_flag)
	);

	// output beat valid flag; the datapath holds the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (publish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_temp};
	assign m_tuser  = out_flag;

	// a published result is always presented next cycle
	a_publish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		publish |=> m_tvalid)
		else $error("published result not presented");

	// never overwrite a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		publish |-> (!m_tvalid || m_tready))
		else $error("result overwritten while waiting");

	// a usable sample's temperature lies in the saturated range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
			($signed(m_tdata[13:0]) >= -14'sd1000 && $signed(m_tdata[13:0]) <= 14'sd6000))
		else $error("temperature outside saturation range");

	// no input taken while a sample is in flight
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while busy");

endmodule
